>>> rtl/tld_pkg.sv
// Shared constants, character codes and types of the text line decorator.
package tld_pkg;

   localparam int unsigned NUMBER_DIGITS = 6;
   localparam int unsigned BCD_W         = 4 * NUMBER_DIGITS;
   localparam int unsigned DIGIT_IDX_W   = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
   localparam int unsigned TAIL_MAX      = 4;
   localparam int unsigned TAIL_LEN_W    = $clog2(TAIL_MAX + 1);
   localparam int unsigned TAIL_IDX_W    = $clog2(TAIL_MAX);
   localparam int unsigned JOB_MAX       = NUMBER_DIGITS + 1 + TAIL_MAX;
   localparam int unsigned POS_W         = $clog2(JOB_MAX);
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 8;

   localparam logic [7:0] CHR_TAB      = 8'h09;
   localparam logic [7:0] CHR_LF       = 8'h0A;
   localparam logic [7:0] CHR_SPACE    = 8'h20;
   localparam logic [7:0] CHR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHR_DASH     = 8'h2D;
   localparam logic [7:0] CHR_ZERO     = 8'h30;
   localparam logic [7:0] CHR_QUESTION = 8'h3F;
   localparam logic [7:0] CHR_AT       = 8'h40;
   localparam logic [7:0] CHR_I        = 8'h49;
   localparam logic [7:0] CHR_M        = 8'h4D;
   localparam logic [7:0] CHR_CARET    = 8'h5E;
   localparam logic [7:0] CHR_DEL      = 8'h7F;
   localparam logic [7:0] CHR_HIGH    = 8'h80;
   localparam logic [7:0] CHR_META_LO  = 8'hA0;
   localparam logic [7:0] CHR_META_DEL = 8'hFF;
   localparam logic [7:0] CHR_CTRL_END = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUMBER_ALL           = 3'd0,
      REG_NUMBER_NONBLANK_ONLY = 3'd1,
      REG_SQUEEZE_BLANKS       = 3'd2,
      REG_MARK_LINE_ENDS       = 3'd3,
      REG_SHOW_TABS_CARET      = 3'd4,
      REG_SHOW_CONTROL         = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic number_all;
      logic number_nonblank_only;
      logic squeeze_blanks;
      logic mark_line_ends;
      logic show_tabs_caret;
      logic show_control;
   } config_type;

   typedef struct packed {
      logic                          numbered;
      logic [BCD_W-1:0]              bcd;
      logic [TAIL_LEN_W-1:0]         tail_len;
      logic [TAIL_MAX-1:0][7:0]      tail;
   } job_type;

endpackage

>>> rtl/tld_if.sv
// Channel interfaces of the text line decorator: input bytes, results and register writes.
interface tld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface tld_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tld_csr_if import tld_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/tld_front.sv
// Front part: configuration registers, line state, line counter and byte classification.
module tld_front import tld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   tld_req_if.sink req,
   tld_csr_if.sink csr,
   output logic    push_valid,
   output job_type push_job,
   input  logic    push_ready
);

   config_type       cfg_ff, cfg_in;
   logic             at_line_start_ff, at_line_start_in;
   logic             prev_blank_ff, prev_blank_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;

   logic [7:0]       b;
   logic             is_lf;
   logic             squeezed;
   logic             numbered;
   logic             all_nines;
   logic             carry;
   logic [BCD_W-1:0] bcd_bumped;
   logic             accept;

   assign csr.ready = 1'b1;
   assign req.ready = push_ready;
   assign b         = req.in_byte;
   assign is_lf     = (b == CHR_LF);
   assign squeezed  = at_line_start_ff && is_lf && cfg_ff.squeeze_blanks && prev_blank_ff;
   assign numbered  = at_line_start_ff &&
                      (cfg_ff.number_nonblank_only ? !is_lf : cfg_ff.number_all);
   assign accept    = req.valid && push_ready && !squeezed;
   assign push_valid = req.valid && !squeezed;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            REG_NUMBER_ALL:           cfg_in.number_all = csr.data[0];
            REG_NUMBER_NONBLANK_ONLY: cfg_in.number_nonblank_only = csr.data[0];
            REG_SQUEEZE_BLANKS:       cfg_in.squeeze_blanks = csr.data[0];
            REG_MARK_LINE_ENDS:       cfg_in.mark_line_ends = csr.data[0];
            REG_SHOW_TABS_CARET:      cfg_in.show_tabs_caret = csr.data[0];
            REG_SHOW_CONTROL:         cfg_in.show_control = csr.data[0];
            default: ;
         endcase
      end
   end

   // Decimal increment of the line count, saturating at all nines.
   always_comb begin
      all_nines  = 1'b1;
      carry      = 1'b1;
      bcd_bumped = bcd_ff;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd9) begin
            all_nines = 1'b0;
         end
         if (carry) begin
            if (bcd_ff[4*i +: 4] == 4'd9) begin
               bcd_bumped[4*i +: 4] = 4'd0;
            end else begin
               bcd_bumped[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      if (all_nines) begin
         bcd_bumped = bcd_ff;
      end
   end

   always_comb begin
      bcd_in           = bcd_ff;
      at_line_start_in = at_line_start_ff;
      prev_blank_in    = prev_blank_ff;
      if (accept) begin
         if (numbered) begin
            bcd_in = bcd_bumped;
         end
         if (is_lf) begin
            prev_blank_in    = at_line_start_ff;
            at_line_start_in = 1'b1;
         end else begin
            at_line_start_in = 1'b0;
         end
      end
   end

   always_comb begin
      push_job          = '0;
      push_job.numbered = numbered;
      push_job.bcd      = numbered ? bcd_bumped : bcd_ff;
      push_job.tail_len = TAIL_LEN_W'(1);
      push_job.tail[0]  = b;
      if (is_lf) begin
         if (cfg_ff.mark_line_ends) begin
            push_job.tail_len = TAIL_LEN_W'(2);
            push_job.tail[0]  = CHR_DOLLAR;
            push_job.tail[1]  = CHR_LF;
         end
      end else if (cfg_ff.show_control && (b < CHR_TAB || (b > CHR_LF && b < CHR_CTRL_END))) begin
         push_job.tail_len = TAIL_LEN_W'(2);
         push_job.tail[0]  = CHR_CARET;
         push_job.tail[1]  = b + CHR_AT;
      end else if (cfg_ff.show_control && b == CHR_DEL) begin
         push_job.tail_len = TAIL_LEN_W'(2);
         push_job.tail[0]  = CHR_CARET;
         push_job.tail[1]  = CHR_QUESTION;
      end else if (cfg_ff.show_control && b >= CHR_HIGH && b < CHR_META_LO) begin
         push_job.tail_len = TAIL_LEN_W'(4);
         push_job.tail[0]  = CHR_M;
         push_job.tail[1]  = CHR_DASH;
         push_job.tail[2]  = CHR_CARET;
         push_job.tail[3]  = b - CHR_AT;
      end else if (cfg_ff.show_control && b >= CHR_META_LO && b != CHR_META_DEL) begin
         push_job.tail_len = TAIL_LEN_W'(3);
         push_job.tail[0]  = CHR_M;
         push_job.tail[1]  = CHR_DASH;
         push_job.tail[2]  = b - CHR_HIGH;
      end else if (cfg_ff.show_control && b == CHR_META_DEL) begin
         push_job.tail_len = TAIL_LEN_W'(4);
         push_job.tail[0]  = CHR_M;
         push_job.tail[1]  = CHR_DASH;
         push_job.tail[2]  = CHR_CARET;
         push_job.tail[3]  = CHR_QUESTION;
      end else if (cfg_ff.show_tabs_caret && b == CHR_TAB) begin
         push_job.tail_len = TAIL_LEN_W'(2);
         push_job.tail[0]  = CHR_CARET;
         push_job.tail[1]  = CHR_I;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         at_line_start_ff <= 1'b1;
         prev_blank_ff    <= 1'b0;
         bcd_ff           <= '0;
      end else begin
         cfg_ff           <= cfg_in;
         at_line_start_ff <= at_line_start_in;
         prev_blank_ff    <= prev_blank_in;
         bcd_ff           <= bcd_in;
      end
   end

   // Every digit of the line count stays a valid decimal digit.
   for (genvar g = 0; g < NUMBER_DIGITS; g++) begin : g_bcd_check
      assert property (@(posedge clock) disable iff (reset) bcd_ff[4*g +: 4] <= 4'd9)
         else $error("Line count digit out of decimal range.");
   end

   // A squeezed blank line leaves the line state untouched.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && push_ready && squeezed) |=> $stable(bcd_ff) && $stable(prev_blank_ff))
      else $error("Squeezed line changed the line state.");

endmodule

>>> rtl/tld_queue.sv
// Short job queue between the front and back parts.
module tld_queue import tld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  job_type in_job,
   output logic    in_ready,
   output logic    out_valid,
   output job_type out_job,
   input  logic    out_ready
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("Job queue overflow.");

endmodule

>>> rtl/tld_back.sv
// Back part: walks one job byte by byte into the registered result stage.
module tld_back import tld_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      job_valid,
   input  job_type   job,
   output logic      job_done,
   tld_rsp_if.source rsp
);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  last_ff, last_in;

   logic                  load;
   logic [POS_W-1:0]      idx;
   logic [POS_W-1:0]      total_len;
   logic                  is_last;
   logic [POS_W-1:0]      digit_k;
   logic [3:0]            digit;
   logic [NUMBER_DIGITS-1:0] shown;
   logic                  seen;
   logic [POS_W-1:0]      tail_off;
   logic [TAIL_IDX_W-1:0] tail_idx;
   logic [7:0]            sel_byte;

   assign load      = job_valid && (!rsp_valid_ff || rsp.ready);
   assign idx       = job.numbered ? pos_ff : pos_ff + POS_W'(NUMBER_DIGITS + 1);
   assign total_len = (job.numbered ? POS_W'(NUMBER_DIGITS + 1) : '0) + POS_W'(job.tail_len);
   assign is_last   = (pos_ff == total_len - POS_W'(1));
   assign job_done  = load && is_last;

   assign digit_k  = POS_W'(NUMBER_DIGITS - 1) - idx;
   assign digit    = 4'(job.bcd >> {digit_k, 2'b00});
   assign tail_off = idx - POS_W'(NUMBER_DIGITS + 1);
   assign tail_idx = tail_off[TAIL_IDX_W-1:0];

   // Leading zeros print as spaces; the lowest digit always prints.
   always_comb begin
      seen = 1'b0;
      for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
         if (job.bcd[4*k +: 4] != 4'd0) begin
            seen = 1'b1;
         end
         shown[k] = seen || (k == 0);
      end
   end

   always_comb begin
      if (idx < POS_W'(NUMBER_DIGITS)) begin
         sel_byte = shown[digit_k[DIGIT_IDX_W-1:0]] ? (CHR_ZERO | {4'd0, digit}) : CHR_SPACE;
      end else if (idx == POS_W'(NUMBER_DIGITS)) begin
         sel_byte = CHR_TAB;
      end else begin
         sel_byte = job.tail[tail_idx];
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      if (load) begin
         pos_in       = is_last ? '0 : pos_ff + POS_W'(1);
         rsp_valid_in = 1'b1;
         out_byte_in  = sel_byte;
         last_in      = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.last_of_run = last_ff;

   assert property (@(posedge clock) disable iff (reset) job_valid |-> pos_ff < total_len)
      else $error("Byte position ran past the end of the job.");

   assert property (@(posedge clock) disable iff (reset) !job_valid |-> pos_ff == '0)
      else $error("Byte position not cleared between jobs.");

endmodule

>>> rtl/text_line_decorator.sv
// Top level of the text line decorator: front part, job queue and back part.
//
// Usage. Text bytes enter on req_if, one per transfer. Decorated bytes leave on rsp_if,
// one per transfer, with last_of_run set on the final byte caused by an input byte.
// Registers are written over csr_if (index 0 to 5, bit 0 of data); csr_if is always
// ready, and writes are expected only while no byte is in flight.
// Each input byte yields 0 to 11 output bytes: a squeezed blank line yields none, a
// numbered line start adds six digit characters and a tab, and caret or M- notation
// adds up to three bytes. The first output byte of an item passes through the job
// queue and the registered result stage before it is valid. The back part sends one
// output byte per cycle while the receiver does not stall, so throughput is one input
// byte per cycle for bytes that expand to a single output byte, and lower for bytes
// that expand to more. A two-entry job queue lets the front part take the next byte
// while the back part is still expanding the previous one.
// When the receiver stalls, the output register holds its byte, the queue fills and
// req_if.ready drops. Reset clears the registers, the line count and the queue; the
// block starts at the beginning of a line.
module text_line_decorator import tld_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tld_req_if.sink   req_if,
   tld_rsp_if.source rsp_if,
   tld_csr_if.sink   csr_if
);

   logic    push_valid;
   job_type push_job;
   logic    push_ready;
   logic    job_valid;
   job_type job;
   logic    job_done;

   tld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .csr        (csr_if),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   tld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_job    (push_job),
      .in_ready  (push_ready),
      .out_valid (job_valid),
      .out_job   (job),
      .out_ready (job_done)
   );

   tld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_done  (job_done),
      .rsp       (rsp_if)
   );

endmodule

>>> tb/tld_tb_pkg.sv
// Scoreboard of the text line decorator: predicted output bytes and their comparison.
package tld_tb_pkg;
   import tld_pkg::*;

   localparam logic [BCD_W-1:0] ALL_NINES = {NUMBER_DIGITS{4'h9}};

   typedef struct packed {
      logic [7:0] text;
      logic       last_flag;
   } expected_byte_type;

   class decor_scoreboard;
      config_type        cfg = '0;
      bit                line_start = 1'b1;
      bit                prev_blank = 1'b0;
      logic [BCD_W-1:0]  count_bcd = '0;
      expected_byte_type expected_text[$];
      int unsigned       errors = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_NUMBER_ALL:           cfg.number_all = value[0];
            REG_NUMBER_NONBLANK_ONLY: cfg.number_nonblank_only = value[0];
            REG_SQUEEZE_BLANKS:       cfg.squeeze_blanks = value[0];
            REG_MARK_LINE_ENDS:       cfg.mark_line_ends = value[0];
            REG_SHOW_TABS_CARET:      cfg.show_tabs_caret = value[0];
            REG_SHOW_CONTROL:         cfg.show_control = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_text.size();
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0] run[$];
         logic [3:0] digit;
         bit         numbered;
         bit         lead;
         bit         carry;
         int         i;
         if (line_start) begin
            if (b == CHR_LF && cfg.squeeze_blanks && prev_blank) return;
            numbered = cfg.number_nonblank_only ? (b != CHR_LF) : cfg.number_all;
            if (numbered) begin
               // The count saturates at all nines and is bumped before it is shown.
               if (count_bcd != ALL_NINES) begin
                  carry = 1'b1;
                  for (i = 0; i < NUMBER_DIGITS; i++) begin
                     if (carry) begin
                        if (count_bcd[4*i +: 4] == 4'd9) begin
                           count_bcd[4*i +: 4] = 4'd0;
                        end else begin
                           count_bcd[4*i +: 4] = count_bcd[4*i +: 4] + 4'd1;
                           carry = 1'b0;
                        end
                     end
                  end
               end
               lead = 1'b1;
               for (i = NUMBER_DIGITS - 1; i >= 0; i--) begin
                  digit = count_bcd[4*i +: 4];
                  if (digit != 4'd0 || i == 0) lead = 1'b0;
                  run.push_back(lead ? CHR_SPACE : CHR_ZERO + 8'(digit));
               end
               run.push_back(CHR_TAB);
            end
         end
         if (b == CHR_LF) begin
            if (cfg.mark_line_ends) run.push_back(CHR_DOLLAR);
            run.push_back(CHR_LF);
            prev_blank = line_start;
            line_start = 1'b1;
         end else begin
            if (cfg.show_control && b < CHR_CTRL_END && b != CHR_TAB) begin
               run.push_back(CHR_CARET);
               run.push_back(b + CHR_AT);
            end else if (cfg.show_control && b == CHR_DEL) begin
               run.push_back(CHR_CARET);
               run.push_back(CHR_QUESTION);
            end else if (cfg.show_control && b >= CHR_HIGH && b < CHR_META_LO) begin
               run.push_back(CHR_M);
               run.push_back(CHR_DASH);
               run.push_back(CHR_CARET);
               run.push_back(b - CHR_AT);
            end else if (cfg.show_control && b >= CHR_META_LO && b != CHR_META_DEL) begin
               run.push_back(CHR_M);
               run.push_back(CHR_DASH);
               run.push_back(b - CHR_HIGH);
            end else if (cfg.show_control && b == CHR_META_DEL) begin
               run.push_back(CHR_M);
               run.push_back(CHR_DASH);
               run.push_back(CHR_CARET);
               run.push_back(CHR_QUESTION);
            end else if (cfg.show_tabs_caret && b == CHR_TAB) begin
               run.push_back(CHR_CARET);
               run.push_back(CHR_I);
            end else begin
               run.push_back(b);
            end
            line_start = 1'b0;
         end
         for (i = 0; i < run.size(); i++) begin
            expected_text.push_back('{text: run[i], last_flag: (i == run.size() - 1)});
         end
      endfunction

      function void check_result(logic [7:0] got_byte, logic got_last);
         expected_byte_type want;
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected transfer: expected none, actual byte %h last %b",
                     $time, got_byte, got_last);
            errors++;
            return;
         end
         want = expected_text.pop_front();
         if (got_byte !== want.text) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.text, got_byte);
            errors++;
         end
         if (got_last !== want.last_flag) begin
            $display("%0t: last_of_run mismatch: expected %b, actual %b",
                     $time, want.last_flag, got_last);
            errors++;
         end
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
// Testbench top of the text line decorator: clock, reset, stimulus, stalls and verdict.
module tb_top import tld_pkg::*, tld_tb_pkg::*;;

   localparam int unsigned CYCLE_LIMIT   = 5_000_000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_ITEMS   = 64;
   localparam int unsigned CFG_W         = $bits(config_type);

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   bit              calm = 1'b0;
   int unsigned     cycle_count = 0;
   int unsigned     items_sent = 0;
   int              hold_left = 0;
   decor_scoreboard board = new();

   tld_req_if req_if();
   tld_rsp_if rsp_if();
   tld_csr_if csr_if();

   text_line_decorator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 8'($urandom_range(32, 126));
      if (r < 63) return CHR_TAB;
      if (r < 72) return 8'($urandom_range(0, 31));
      if (r < 78) return CHR_DEL;
      if (r < 92) return 8'($urandom_range(128, 255));
      return 8'($urandom);
   endfunction

   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.out_byte, rsp_if.last_of_run);
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         hold_left = pick_gap();
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: errors");
      $finish;
   end

   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      board.note_byte(b);
      items_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(config_type c);
      logic [CSR_DATA_W-1:0] value;
      int                    k;
      for (k = 0; k < 2**CSR_IDX_W; k++) begin
         value = CSR_DATA_W'($urandom);
         case (CSR_IDX_W'(k))
            REG_NUMBER_ALL:           value[0] = c.number_all;
            REG_NUMBER_NONBLANK_ONLY: value[0] = c.number_nonblank_only;
            REG_SQUEEZE_BLANKS:       value[0] = c.squeeze_blanks;
            REG_MARK_LINE_ENDS:       value[0] = c.mark_line_ends;
            REG_SHOW_TABS_CARET:      value[0] = c.show_tabs_caret;
            REG_SHOW_CONTROL:         value[0] = c.show_control;
            default: ;
         endcase
         csr_if.valid <= 1'b1;
         csr_if.index <= CSR_IDX_W'(k);
         csr_if.data  <= value;
         do @(posedge clock); while (!csr_if.ready);
         board.write_reg(CSR_IDX_W'(k), value);
      end
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_line();
      int len;
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 25) len = 0;
      else if (r < 95) len = $urandom_range(1, 12);
      else len = $urandom_range(30, 60);
      for (k = 0; k < len; k++) send_byte(pick_text_byte());
      send_byte(CHR_LF);
   endtask

   initial begin
      config_type       c;
      logic [CFG_W-1:0] cfg_bits;
      int               phase;
      int unsigned      target;
      int               k;
      req_if.valid   <= 1'b0;
      req_if.in_byte <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= '0;
      csr_if.data    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // With every option on, nonblank numbering wins and repeated blank lines vanish.
      program_regs('1);
      send_byte(CHR_LF);
      send_byte(CHR_LF);
      send_byte(8'h41);
      send_byte(CHR_TAB);
      send_byte(8'h00);
      send_byte(8'h08);
      send_byte(8'h0B);
      send_byte(8'h1F);
      send_byte(CHR_SPACE);
      send_byte(8'h7E);
      send_byte(CHR_DEL);
      send_byte(CHR_HIGH);
      send_byte(8'h9F);
      send_byte(CHR_META_LO);
      send_byte(8'hFE);
      send_byte(CHR_META_DEL);
      send_byte(CHR_LF);
      send_byte(CHR_LF);
      send_byte(CHR_LF);
      drain();

      c = '0;
      c.number_all = 1'b1;
      program_regs(c);
      send_byte(CHR_LF);
      send_byte(CHR_TAB);
      send_byte(8'h7A);
      send_byte(CHR_LF);
      send_byte(CHR_LF);
      drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            c = '0;
         end else if (phase == 1) begin
            c = '1;
         end else begin
            cfg_bits = CFG_W'($urandom);
            c = config_type'(cfg_bits);
         end
         calm = (phase == 1) || ($urandom_range(0, 3) == 0);
         program_regs(c);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
               send_line();
            end else begin
               for (k = $urandom_range(1, 6); k > 0; k--) send_byte(8'($urandom));
            end
         end
         drain();
      end

      if (board.errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

>>> files.f
rtl/tld_pkg.sv
rtl/tld_if.sv
rtl/tld_front.sv
rtl/tld_queue.sv
rtl/tld_back.sv
rtl/text_line_decorator.sv
tb/tld_tb_pkg.sv
tb/tb_top.sv
